[rtl/core/mked_pkg.sv]
// Shared types and constants for the multi-key edge debouncer.
package mked_pkg;

	localparam int KEY_COUNT  = 10;
	localparam int LEVEL_BITS = 10;
	localparam int KEY_IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int KEY_ID_W   = 4;
	localparam int TIME_W     = 32;
	localparam int WIN_W      = 16;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [WIN_W-1:0] DEBOUNCE_RESET = WIN_W'(30);

	// Item modes
	typedef enum logic [1:0] {
		MODE_EDGE   = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_INIT   = 2'd3
	} mode_t;

	// Register indexes (word index into the APB map)
	typedef enum logic {
		REG_DEBOUNCE = 1'b0,
		REG_PRESSED  = 1'b1
	} reg_idx_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [WIN_W-1:0] debounce;
		logic             pressed_level;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

[rtl/core/mked_cfg.sv]
// APB register file: lockout window and pressed level.
module mked_cfg import mked_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [WIN_W-1:0] debounce_q;
	logic             pressed_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			pressed_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE: debounce_q <= pwdata[WIN_W-1:0];
				REG_PRESSED:  pressed_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (idx)
			REG_DEBOUNCE: prdata = {{(DATA_W-WIN_W){1'b0}}, debounce_q};
			REG_PRESSED:  prdata = {{(DATA_W-1){1'b0}}, pressed_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.debounce      = debounce_q;
	assign cfg.pressed_level = pressed_q;

endmodule

[rtl/core/mked_ctrl.sv]
// Controller: input acceptance, execute step and output valid.
module mked_ctrl import mked_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   can_exec;

	// Result slot is free or is being drained this cycle
	assign can_exec = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: if (can_exec) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: cmd.exec = can_exec;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted beat always enters execute next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted beat did not enter execute");

	// Stalled result holds the execute step back
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !out_ready) |-> !cmd.exec)
		else $error("execute overwrote a pending result");

	// Every execute step produces a result
	a_exec_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("execute step lost its result");

endmodule

[rtl/core/mked_dp.sv]
// Datapath: input register, per-key state, lockout test, result register.
module mked_dp import mked_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  cfg_t                  cfg,
	input  logic [1:0]            mode,
	input  logic [KEY_ID_W-1:0]   key_id,
	input  logic                  pin_level,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [LEVEL_BITS-1:0] initial_levels,
	output logic                  key_down,
	output logic                  press_event,
	output logic                  release_event
);

	// Captured beat
	mode_t                 mode_q;
	logic [KEY_ID_W-1:0]   key_q;
	logic                  pin_q;
	logic [TIME_W-1:0]     now_q;
	logic [LEVEL_BITS-1:0] levels_q;

	// Per-key state
	logic [KEY_COUNT-1:0] stable_q, stable_d;
	logic [KEY_COUNT-1:0] pp_q, pp_d;
	logic [KEY_COUNT-1:0] pr_q, pr_d;
	logic [KEY_COUNT-1:0] lp_q, lp_d;
	logic [KEY_COUNT-1:0] lr_q, lr_d;
	logic [TIME_W-1:0]    last_q [KEY_COUNT];
	logic [TIME_W-1:0]    last_d [KEY_COUNT];

	logic                 key_down_q, press_q, release_q;
	logic                 key_ok;
	logic [KEY_IDX_W-1:0] kidx;
	logic [TIME_W-1:0]    elapsed;
	logic [TIME_W-1:0]    window;
	logic                 edge_ok;
	logic                 pressed;
	logic [TIME_W-1:0]    init_time;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(mode);
			key_q    <= key_id;
			pin_q    <= pin_level;
			now_q    <= now_ms;
			levels_q <= initial_levels;
		end
	end

	// Lockout test for the addressed key
	assign key_ok    = ({1'b0, key_q} < (KEY_ID_W+1)'(KEY_COUNT));
	assign kidx      = key_q[KEY_IDX_W-1:0];
	assign window    = {{(TIME_W-WIN_W){1'b0}}, cfg.debounce};
	assign elapsed   = now_q - last_q[kidx];
	assign edge_ok   = key_ok && (elapsed >= window);
	assign pressed   = (pin_q == cfg.pressed_level);
	assign init_time = now_q - window;

	// Next per-key state
	always_comb begin
		stable_d = stable_q;
		pp_d     = pp_q;
		pr_d     = pr_q;
		lp_d     = lp_q;
		lr_d     = lr_q;
		last_d   = last_q;
		unique case (mode_q)
			MODE_EDGE: begin
				if (edge_ok) begin
					last_d[kidx] = now_q;
					if (pressed != stable_q[kidx]) begin
						stable_d[kidx] = pressed;
						if (pressed) pp_d[kidx] = 1'b1;
						else pr_d[kidx] = 1'b1;
					end
				end
			end
			MODE_UPDATE: begin
				lp_d = pp_q;
				lr_d = pr_q;
				pp_d = '0;
				pr_d = '0;
			end
			MODE_QUERY: ;
			MODE_INIT: begin
				for (int i = 0; i < KEY_COUNT; i++) begin
					stable_d[i] = ((i < LEVEL_BITS) ? levels_q[i % LEVEL_BITS] : 1'b0)
						== cfg.pressed_level;
					last_d[i] = init_time;
				end
				pp_d = '0;
				pr_d = '0;
				lp_d = '0;
				lr_d = '0;
			end
			default: ;
		endcase
	end

	// State and result update on execute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			pp_q     <= '0;
			pr_q     <= '0;
			lp_q     <= '0;
			lr_q     <= '0;
			for (int i = 0; i < KEY_COUNT; i++) last_q[i] <= '0;
		end else if (cmd.exec) begin
			stable_q <= stable_d;
			pp_q     <= pp_d;
			pr_q     <= pr_d;
			lp_q     <= lp_d;
			lr_q     <= lr_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			key_down_q <= key_ok && stable_d[kidx];
			press_q    <= key_ok && lp_d[kidx];
			release_q  <= key_ok && lr_d[kidx];
		end
	end

	assign key_down      = key_down_q;
	assign press_event   = press_q;
	assign release_event = release_q;

	// Out-of-range key reports all zeros
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !key_ok) |=> (!key_down_q && !press_q && !release_q))
		else $error("out-of-range key gave a nonzero status");

	// Query leaves key state alone
	a_query_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && mode_q == MODE_QUERY) |=>
		($stable(stable_q) && $stable(pp_q) && $stable(pr_q) && $stable(lp_q)))
		else $error("query changed key state");

	// Update leaves no pending flags
	a_update_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && mode_q == MODE_UPDATE) |=> (pp_q == '0 && pr_q == '0))
		else $error("update left pending flags set");

endmodule

[rtl/core/multi_key_edge_debouncer.sv]
// Top level of the multi-key edge debouncer.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one beat per item: mode, key_id,
//    pin_level, now_ms and initial_levels. Output channel (out_valid/out_ready)
//    returns one beat per item: key_down, press_event, release_event.
//  - An item is first captured into the input register; the execute step then
//    runs the lockout test and per-key update and loads the result register.
//    A new beat is accepted only after the previous item has left execute.
//  - The output register decouples the sides: a new beat is accepted while a
//    result waits. If the receiver stalls, the next item holds in execute until
//    the waiting result is taken, and the input does not accept meanwhile.
//  - Reset clears all key state and flags to zero, sets the lockout window to
//    30 ticks and the pressed level to low.
//  - APB registers: 0x0 lockout window (16 bit), 0x4 pressed level (1 bit).
//    Write them only while the block is idle.
module multi_key_edge_debouncer import mked_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [KEY_ID_W-1:0]   key_id,
	input  logic                  pin_level,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [LEVEL_BITS-1:0] initial_levels,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  key_down,
	output logic                  press_event,
	output logic                  release_event
);

	cfg_t cfg;
	cmd_t cmd;

	mked_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mked_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mked_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.mode           (mode),
		.key_id         (key_id),
		.pin_level      (pin_level),
		.now_ms         (now_ms),
		.initial_levels (initial_levels),
		.key_down       (key_down),
		.press_event    (press_event),
		.release_event  (release_event)
	);

endmodule

[tb/multi_key_edge_debouncer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the multi-key edge debouncer with a built-in key-state predictor.
module multi_key_edge_debouncer_tb;
	import mked_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 210;
	localparam int DIR_ROWS    = 18;

	// One result beat: {key_down, press_event, release_event}
	typedef struct packed {
		logic key_down;
		logic press_event;
		logic release_event;
	} key_status_t;

	// One stimulus row; want is used only when fixed is set
	typedef struct packed {
		mode_t                 m;
		logic [KEY_ID_W-1:0]   id;
		logic                  pin;
		logic [TIME_W-1:0]     now;
		logic [LEVEL_BITS-1:0] levels;
		logic                  fixed;
		key_status_t           want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	mode_t                 mode;
	logic [KEY_ID_W-1:0]   key_id;
	logic                  pin_level;
	logic [TIME_W-1:0]     now_ms;
	logic [LEVEL_BITS-1:0] initial_levels;
	logic                  out_valid;
	logic                  out_ready;
	logic                  key_down;
	logic                  press_event;
	logic                  release_event;

	// Predicted key state and configuration
	logic              stable_down  [KEY_COUNT];
	logic              pend_press   [KEY_COUNT];
	logic              pend_release [KEY_COUNT];
	logic              evt_press    [KEY_COUNT];
	logic              evt_release  [KEY_COUNT];
	logic [TIME_W-1:0] last_edge    [KEY_COUNT];
	logic [WIN_W-1:0]  cfg_debounce;
	logic              cfg_pressed;

	key_status_t status_q[$];
	int          mismatch_cnt;
	int          cycle_cnt;
	int          gap_pct;
	int          stall_pct;
	int          hold_req;
	int          hold_left;

	int ph_gap   [PHASES] = '{0, 49, 0, 22, 0, 22};
	int ph_stall [PHASES] = '{0, 0, 49, 22, 0, 22};

	stim_row_t dir_tab [DIR_ROWS];

	multi_key_edge_debouncer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.key_id        (key_id),
		.pin_level     (pin_level),
		.now_ms        (now_ms),
		.initial_levels(initial_levels),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_down      (key_down),
		.press_event   (press_event),
		.release_event (release_event)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one item to the predicted state and returns the addressed key's status
	function automatic key_status_t debounce_step(mode_t m, logic [KEY_ID_W-1:0] id, logic pin,
			logic [TIME_W-1:0] now, logic [LEVEL_BITS-1:0] levels);
		key_status_t       res;
		logic [TIME_W-1:0] elapsed;
		logic              pressed;
		logic              raw;
		bit                in_range;
		in_range = int'(id) < KEY_COUNT;
		case (m)
			MODE_EDGE: begin
				if (in_range) begin
					// lockout test wraps modulo 2^32
					elapsed = now - last_edge[id];
					if (elapsed >= TIME_W'(cfg_debounce)) begin
						pressed = (pin == cfg_pressed);
						last_edge[id] = now;
						if (pressed != stable_down[id]) begin
							stable_down[id] = pressed;
							if (pressed)
								pend_press[id] = 1'b1;
							else
								pend_release[id] = 1'b1;
						end
					end
				end
			end
			MODE_UPDATE: begin
				for (int i = 0; i < KEY_COUNT; i++) begin
					evt_press[i]    = pend_press[i];
					evt_release[i]  = pend_release[i];
					pend_press[i]   = 1'b0;
					pend_release[i] = 1'b0;
				end
			end
			MODE_INIT: begin
				for (int i = 0; i < KEY_COUNT; i++) begin
					raw = (i < LEVEL_BITS) ? levels[i] : 1'b0;
					stable_down[i]  = (raw == cfg_pressed);
					pend_press[i]   = 1'b0;
					pend_release[i] = 1'b0;
					evt_press[i]    = 1'b0;
					evt_release[i]  = 1'b0;
					last_edge[i]    = now - TIME_W'(cfg_debounce);
				end
			end
			default: ;
		endcase
		if (in_range) begin
			res.key_down      = stable_down[id];
			res.press_event   = evt_press[id];
			res.release_event = evt_release[id];
		end else begin
			res = '0;
		end
		return res;
	endfunction

	// APB write: setup then access; register updates at the access edge
	task automatic apb_write(reg_idx_t r, logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({r, 2'b00});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_DEBOUNCE: cfg_debounce = v[WIN_W-1:0];
			REG_PRESSED:  cfg_pressed  = v[0];
			default: ;
		endcase
	endtask

	// Offers one beat after a random gap and records its expected status
	task automatic send_item(stim_row_t row);
		key_status_t pred;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= row.m;
		key_id         <= row.id;
		pin_level      <= row.pin;
		now_ms         <= row.now;
		initial_levels <= row.levels;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = debounce_step(row.m, row.id, row.pin, row.now, row.levels);
		status_q.push_back(row.fixed ? row.want : pred);
	endtask

	// Drops valid and waits until every expected beat has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls plus an occasional long hold-off
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		key_status_t got;
		key_status_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {key_down, press_event, release_event};
			if (status_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result beat with nothing expected: %b", $realtime, got);
			end else begin
				want = status_q.pop_front();
				if (got.key_down !== want.key_down || got.press_event !== want.press_event ||
						got.release_event !== want.release_event) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: mismatch key_down %b/%b press %b/%b release %b/%b (exp/act)",
							$realtime, want.key_down, got.key_down, want.press_event,
							got.press_event, want.release_event, got.release_event);
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[multi_key_edge_debouncer] ERROR");
		$finish;
	end

	// Main sequence
	initial begin
		stim_row_t           row;
		logic [TIME_W-1:0]   tick;
		logic [KEY_ID_W-1:0] hot_id;
		int                  r;

		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		mode           = MODE_QUERY;
		key_id         = '0;
		pin_level      = 1'b0;
		now_ms         = '0;
		initial_levels = '0;
		mismatch_cnt   = 0;
		hold_req       = 0;
		gap_pct        = 0;
		stall_pct      = 0;
		cfg_debounce   = DEBOUNCE_RESET;
		cfg_pressed    = 1'b0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			stable_down[i]  = 1'b0;
			pend_press[i]   = 1'b0;
			pend_release[i] = 1'b0;
			evt_press[i]    = 1'b0;
			evt_release[i]  = 1'b0;
			last_edge[i]    = '0;
		end

		// Directed rows, reset config (window 30, active low)
		// fields: mode, key, pin, now, levels, fixed, {down, press, release}
		dir_tab = '{
			'{MODE_QUERY,  4'd0,  1'b0, 32'd0,         10'h000, 1'b1, 3'b000}, // after reset
			'{MODE_EDGE,   4'd0,  1'b0, 32'd5,         10'h000, 1'b1, 3'b000}, // inside first window
			'{MODE_EDGE,   4'd0,  1'b0, 32'd30,        10'h000, 1'b1, 3'b100}, // window just over
			'{MODE_UPDATE, 4'd0,  1'b0, 32'd31,        10'h000, 1'b1, 3'b110},
			'{MODE_QUERY,  4'd15, 1'b1, 32'd40,        10'h3FF, 1'b1, 3'b000}, // out of range
			'{MODE_EDGE,   4'd15, 1'b0, 32'd1000,      10'h000, 1'b1, 3'b000},
			'{MODE_EDGE,   4'd9,  1'b0, 32'hFFFF_FFFF, 10'h000, 1'b0, 3'b000},
			'{MODE_EDGE,   4'd9,  1'b1, 32'd5,         10'h000, 1'b0, 3'b000}, // wrapped, locked
			'{MODE_EDGE,   4'd9,  1'b1, 32'd29,        10'h000, 1'b0, 3'b000},
			'{MODE_UPDATE, 4'd10, 1'b0, 32'd30,        10'h000, 1'b1, 3'b000},
			'{MODE_QUERY,  4'd9,  1'b0, 32'd31,        10'h000, 1'b0, 3'b000},
			'{MODE_INIT,   4'd3,  1'b1, 32'd100,       10'h3FF, 1'b0, 3'b000},
			'{MODE_INIT,   4'd9,  1'b0, 32'd0,         10'h000, 1'b0, 3'b000}, // backdate wraps
			'{MODE_EDGE,   4'd2,  1'b1, 32'd0,         10'h000, 1'b0, 3'b000},
			'{MODE_EDGE,   4'd2,  1'b0, 32'd29,        10'h000, 1'b0, 3'b000},
			'{MODE_INIT,   4'd12, 1'b0, 32'hFFFF_FFF0, 10'h155, 1'b1, 3'b000},
			'{MODE_EDGE,   4'd1,  1'b0, 32'h0000_000E, 10'h2AA, 1'b0, 3'b000},
			'{MODE_UPDATE, 4'd1,  1'b1, 32'h0000_000F, 10'h000, 1'b0, 3'b000}
		};

		// Reset
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIR_ROWS; k++)
			send_item(dir_tab[k]);
		drain_results();

		// Random phases, each with its own config and idling mix
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apb_write(REG_DEBOUNCE, DATA_W'(0));
				1: apb_write(REG_DEBOUNCE, DATA_W'(16'hFFFF));
				2: apb_write(REG_DEBOUNCE, DATA_W'(30));
				3: apb_write(REG_DEBOUNCE, DATA_W'(1));
				4: apb_write(REG_DEBOUNCE, DATA_W'($urandom_range(2, 200)));
				default: apb_write(REG_DEBOUNCE, DATA_W'($urandom_range(100, 5000)));
			endcase
			apb_write(REG_PRESSED, (p == PHASES - 1) ? DATA_W'($urandom_range(0, 1)) :
				DATA_W'(p % 2 == 0));
			gap_pct   = ph_gap[p];
			stall_pct = ph_stall[p];
			tick      = (p % 2 == 0) ? (32'hFFFF_F000 + $urandom_range(0, 32'hFFF)) : $urandom;
			hot_id    = '0;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver holds off while items keep coming
				if (p == 0 && k == 40)
					hold_req = 300;
				// sender waits for every result
				if (k == 120)
					drain_results();

				r = $urandom_range(0, 99);
				row.m = (r < 62) ? MODE_EDGE : (r < 80) ? MODE_UPDATE :
					(r < 95) ? MODE_QUERY : MODE_INIT;
				if ($urandom_range(0, 99) < 40)
					row.id = hot_id;
				else if ($urandom_range(0, 9) == 0)
					row.id = KEY_ID_W'($urandom_range(KEY_COUNT, 15));
				else
					row.id = KEY_ID_W'($urandom_range(0, KEY_COUNT - 1));
				hot_id = row.id;
				row.pin = 1'($urandom_range(0, 1));
				// time advances in steps near the window so both sides of it are hit
				tick = tick + TIME_W'($urandom_range(0, cfg_debounce / 3 + 2));
				row.now    = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : tick;
				row.levels = LEVEL_BITS'($urandom);
				row.fixed  = 1'b0;
				row.want   = '0;
				send_item(row);
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && status_q.size() == 0)
			$display("[multi_key_edge_debouncer] OK");
		else
			$display("[multi_key_edge_debouncer] ERROR");
		$finish;
	end

endmodule
